FILE: hdl/bdhd_pkg.sv
// Package for the button debouncer with hold detection.
// Types, widths and register index codes. No dependencies.
`timescale 1ns / 1ps

package bdhd_pkg;

    // Width of the saturating age counters (range 4 to 32)
    localparam int AGE_BITS   = 16;
    // Width of the configuration registers
    localparam int LIMIT_BITS = 16;
    // Common width for comparing an age against a limit
    localparam int CMP_BITS   = (AGE_BITS > LIMIT_BITS) ? AGE_BITS : LIMIT_BITS;

    typedef logic [AGE_BITS-1:0]   age_t;
    typedef logic [LIMIT_BITS-1:0] limit_t;
    typedef logic [CMP_BITS-1:0]   cmp_t;

    typedef enum logic [0:0] {
        CFG_DEBOUNCE_LIMIT = 1'b0,
        CFG_HOLD_LIMIT     = 1'b1
    } cfg_index_t;

    localparam limit_t DEBOUNCE_LIMIT_RESET = LIMIT_BITS'(20);
    localparam limit_t HOLD_LIMIT_RESET     = LIMIT_BITS'(1000);

endpackage

FILE: hdl/button_debounce_hold_detector.sv
// Button debouncer with press and hold (long-press) event detection.
// Top level; depends on bdhd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one pin sample per beat:
//   raw_level (active low), ms_tick (one millisecond elapsed since the
//   previous beat) and suppress_request.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   input beat: press_event, hold_event, debounced_level, hold_blocked.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 debounce_limit, 1 hold_limit) at the clock edge; write only while
//   the block is idle.
//   Result: the result of a beat is registered and valid in the cycle after acceptance.
//   Throughput: one beat per cycle unless a held result stalls; the
//   whole update is a pair of counter increments and limit compares
//   between the state registers and the result register.
//   Stalls: a held result blocks the input only while out_ready is low;
//   in_ready = !out_valid || out_ready.
//   Reset: button assumed released, ages cleared, no result pending,
//   limits back to 20 ms and 1000 ms.
`timescale 1ns / 1ps

module button_debounce_hold_detector
    import bdhd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  limit_t           cfg_data,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic             raw_level,
    input  logic             ms_tick,
    input  logic             suppress_request,

    output logic             out_valid,
    input  logic             out_ready,
    output logic             press_event,
    output logic             hold_event,
    output logic             debounced_level,
    output logic             hold_blocked
);

    limit_t debounce_limit_reg;
    limit_t hold_limit_reg;

    logic   previous_raw_reg, previous_raw_next;
    age_t   raw_age_reg,      raw_age_next;
    logic   stable_level_reg, stable_level_next;
    age_t   press_age_reg,    press_age_next;
    logic   hold_done_reg,    hold_done_next;
    logic   suppressed_reg,   suppressed_next;

    logic   out_valid_reg;
    logic   press_event_reg,  press_event_next;
    logic   hold_event_reg,   hold_event_next;

    logic   accept;

    assign in_ready        = !out_valid_reg || out_ready;
    assign accept          = in_valid && in_ready;
    assign out_valid       = out_valid_reg;
    assign press_event     = press_event_reg;
    assign hold_event      = hold_event_reg;
    assign debounced_level = stable_level_reg;
    assign hold_blocked    = suppressed_reg;

    always_comb
    begin
        previous_raw_next = previous_raw_reg;
        raw_age_next      = raw_age_reg;
        stable_level_next = stable_level_reg;
        press_age_next    = press_age_reg;
        hold_done_next    = hold_done_reg;
        suppressed_next   = suppressed_reg;
        press_event_next  = 1'b0;
        hold_event_next   = 1'b0;

        // saturating millisecond ages
        if (ms_tick)
        begin
            if (raw_age_next != '1)
            begin
                raw_age_next = raw_age_next + AGE_BITS'(1);
            end
            if (press_age_next != '1)
            begin
                press_age_next = press_age_next + AGE_BITS'(1);
            end
        end

        if (raw_level != previous_raw_next)
        begin
            previous_raw_next = raw_level;
            raw_age_next      = '0;
        end

        if (CMP_BITS'(raw_age_next) >= CMP_BITS'(debounce_limit_reg))
        begin
            if (raw_level)
            begin
                suppressed_next = 1'b0;
            end
            if (raw_level != stable_level_next)
            begin
                stable_level_next = raw_level;
                hold_done_next    = 1'b0;
                if (!raw_level)
                begin
                    press_age_next   = '0;
                    press_event_next = 1'b1;
                end
            end
        end

        if (!stable_level_next && !hold_done_next && !suppressed_next &&
            CMP_BITS'(press_age_next) >= CMP_BITS'(hold_limit_reg))
        begin
            hold_done_next  = 1'b1;
            hold_event_next = 1'b1;
        end

        if (suppress_request && (!previous_raw_next || !stable_level_next))
        begin
            suppressed_next = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit_reg <= DEBOUNCE_LIMIT_RESET;
            hold_limit_reg     <= HOLD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg_data;
                CFG_HOLD_LIMIT:     hold_limit_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // debounce state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_raw_reg <= 1'b1;
            raw_age_reg      <= '0;
            stable_level_reg <= 1'b1;
            press_age_reg    <= '0;
            hold_done_reg    <= 1'b0;
            suppressed_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                previous_raw_reg <= previous_raw_next;
                raw_age_reg      <= raw_age_next;
                stable_level_reg <= stable_level_next;
                press_age_reg    <= press_age_next;
                hold_done_reg    <= hold_done_next;
                suppressed_reg   <= suppressed_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    // event flags of the pending result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            press_event_reg <= press_event_next;
            hold_event_reg  <= hold_event_next;
        end
    end

endmodule
